[design/pbrf_pkg.sv]
// Shared types, constants and codes of the panel border rectangle filter.
`timescale 1ns / 1ps
package pbrf_pkg;

  localparam int MaxExclude = 8;
  localparam int MaxLines   = 16;

  localparam int ExclAddrW = $clog2(MaxExclude);
  localparam int KeptAddrW = $clog2(MaxLines);
  localparam int ExclCntW  = $clog2(MaxExclude + 1);
  localparam int KeptCntW  = $clog2(MaxLines + 1);
  localparam int IdxW      = (ExclCntW > KeptCntW) ? ExclCntW : KeptCntW;

  localparam int CoordW  = 17;
  localparam int ScreenW = 18;
  localparam int CmpW    = 19;
  localparam int LocW    = 16;
  localparam int CfgW    = 16;
  localparam int LinesW  = 5;
  localparam int SlotW   = 4;

  localparam int InDataW  = 72;
  localparam int InUserW  = 4;
  localparam int OutDataW = 72;
  localparam int OutUserW = 3;
  localparam int CfgAddrW = 3;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_EXCL  = 2'd1,
    REQ_PANEL = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_KEPT    = 3'd0,
    ST_ACK     = 3'd1,
    ST_SKIP    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BLOCKED = 3'd4,
    ST_DUP     = 3'd5,
    ST_LIMIT   = 3'd6,
    ST_FULL    = 3'd7
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_OVL_LEFT   = 3'd0,
    CFG_OVL_TOP    = 3'd1,
    CFG_OVL_RIGHT  = 3'd2,
    CFG_OVL_BOTTOM = 3'd3,
    CFG_ORIGIN_X   = 3'd4,
    CFG_ORIGIN_Y   = 3'd5,
    CFG_MAX_LINES  = 3'd6
  } cfg_addr_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CLIP,
    FSM_CHECK,
    FSM_SCAN_EXCL,
    FSM_SCAN_KEPT,
    FSM_RESP
  } fsm_e;

  // Input rectangle, client space or overlay-local exclusion region.
  typedef struct packed {
    logic signed [CoordW-1:0] b;
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] l;
  } area_t;

  // Overlay-local rectangle.
  typedef struct packed {
    logic [LocW-1:0] b;
    logic [LocW-1:0] r;
    logic [LocW-1:0] t;
    logic [LocW-1:0] l;
  } loc_rect_t;

  typedef struct packed {
    logic signed [CfgW-1:0] left;
    logic signed [CfgW-1:0] top;
    logic signed [CfgW-1:0] right;
    logic signed [CfgW-1:0] bottom;
    logic signed [CfgW-1:0] org_x;
    logic signed [CfgW-1:0] org_y;
  } geom_t;

  typedef struct packed {
    loc_rect_t loc;
    logic      empty;
  } clip_res_t;

endpackage

[design/pbrf_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module pbrf_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pbrf_clip.sv]
// Panel shift to screen space, clamp to the overlay and conversion to overlay-local edges.
`timescale 1ns / 1ps
module pbrf_clip
  import pbrf_pkg::*;
(
  input  logic      clk_i,
  input  area_t     area_i,
  input  geom_t     geom_i,
  output clip_res_t res_o
);

  logic signed [ScreenW-1:0] sl_d, st_d, sr_d, sb_d;
  logic signed [ScreenW-1:0] sl_q, st_q, sr_q, sb_q;
  logic signed [ScreenW-1:0] ovl_l, ovl_t, ovl_r, ovl_b;
  logic                      panel_empty_d, panel_empty_q;
  logic [ScreenW-1:0]        dl, dt, dr, db;

  assign ovl_l = ScreenW'(geom_i.left);
  assign ovl_t = ScreenW'(geom_i.top);
  assign ovl_r = ScreenW'(geom_i.right);
  assign ovl_b = ScreenW'(geom_i.bottom);

  // Stage one: shift by the client origin and clamp against the overlay.
  always_comb begin
    sl_d = ScreenW'(area_i.l) + ScreenW'(geom_i.org_x);
    st_d = ScreenW'(area_i.t) + ScreenW'(geom_i.org_y);
    sr_d = ScreenW'(area_i.r) + ScreenW'(geom_i.org_x);
    sb_d = ScreenW'(area_i.b) + ScreenW'(geom_i.org_y);
    if (sl_d < ovl_l) sl_d = ovl_l;
    if (st_d < ovl_t) st_d = ovl_t;
    if (sr_d > ovl_r) sr_d = ovl_r;
    if (sb_d > ovl_b) sb_d = ovl_b;
    panel_empty_d = (area_i.r <= area_i.l) || (area_i.b <= area_i.t);
  end

  always_ff @(posedge clk_i) begin
    sl_q          <= sl_d;
    st_q          <= st_d;
    sr_q          <= sr_d;
    sb_q          <= sb_d;
    panel_empty_q <= panel_empty_d;
  end

  // Stage two: empty test and overlay-local edges; valid only when not empty.
  assign dl = sl_q - ovl_l;
  assign dt = st_q - ovl_t;
  assign dr = sr_q - ovl_l;
  assign db = sb_q - ovl_t;

  assign res_o.empty = panel_empty_q || (sr_q <= sl_q) || (sb_q <= st_q);
  assign res_o.loc.l = dl[LocW-1:0];
  assign res_o.loc.t = dt[LocW-1:0];
  assign res_o.loc.r = dr[LocW-1:0];
  assign res_o.loc.b = db[LocW-1:0];

endmodule

[design/panel_border_rect_filter.sv]
// Top level: item sequencer over the exclusion and kept-rectangle memories.
//
//   channel  | dir | handshake                | payload
//   s_axis   | in  | s_axis_tvalid/tready     | tdata: area l,t,r,b; tuser: type,usable,monitor
//   m_axis   | out | m_axis_tvalid/tready     | tdata: local l,t,r,b, slot; tuser: status
//   cfg      | in  | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
//
// Control items go from acceptance straight to the result state. A panel item
// passes the clip and check states, then the one-entry-per-cycle scans of the
// E stored exclusions and K kept rectangles, which stop at the first hit.
// Reset clears the counts, the control state and the configuration; the memories need no clearing.
// The result register frees the sequencer as soon as the result is loaded.
`timescale 1ns / 1ps
module panel_border_rect_filter
  import pbrf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // area_left[16:0], area_top[33:17], area_right[50:34], area_bottom[67:51], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // req_type[1:0], usable[2], is_monitor[3]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // local_left[15:0], local_top[31:16], local_right[47:32], local_bottom[63:48],
  // slot[67:64], zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [OutUserW-1:0] m_axis_tuser_o,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  geom_t               geom_q;
  logic [LinesW-1:0]   max_lines_q;

  fsm_e                state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                pend_q, pend_d;
  status_e             res_status_q, res_status_d;
  logic [SlotW-1:0]    res_slot_q, res_slot_d;
  logic [ExclCntW-1:0] excl_cnt_q, excl_cnt_d;
  logic [KeptCntW-1:0] kept_cnt_q, kept_cnt_d;
  loc_rect_t           loc_q, loc_d;

  area_t               item_area_q;
  logic                item_usable_q, item_mon_q;
  area_t               in_area;
  req_e                in_req;
  logic                accept;

  clip_res_t           clip_res;

  logic                excl_we, excl_re, kept_we, kept_re;
  logic [$bits(area_t)-1:0]     excl_rdata;
  logic [$bits(loc_rect_t)-1:0] kept_rdata;
  area_t               ex;
  loc_rect_t           kr;

  logic [KeptCntW-1:0] limit;
  logic                blocked, dup, issue, out_load;

  logic                    m_valid_q;
  logic [OutDataW-1:0]     m_data_q;
  logic [OutUserW-1:0]     m_user_q;

  assign in_area.l = s_axis_tdata_i[CoordW-1:0];
  assign in_area.t = s_axis_tdata_i[2*CoordW-1:CoordW];
  assign in_area.r = s_axis_tdata_i[3*CoordW-1:2*CoordW];
  assign in_area.b = s_axis_tdata_i[4*CoordW-1:3*CoordW];
  assign in_req    = req_e'(s_axis_tuser_i[1:0]);

  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q      <= '0;
      max_lines_q <= LinesW'(MaxLines);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_OVL_LEFT:   geom_q.left   <= cfg_wdata_i;
        CFG_OVL_TOP:    geom_q.top    <= cfg_wdata_i;
        CFG_OVL_RIGHT:  geom_q.right  <= cfg_wdata_i;
        CFG_OVL_BOTTOM: geom_q.bottom <= cfg_wdata_i;
        CFG_ORIGIN_X:   geom_q.org_x  <= cfg_wdata_i;
        CFG_ORIGIN_Y:   geom_q.org_y  <= cfg_wdata_i;
        CFG_MAX_LINES:  max_lines_q   <= cfg_wdata_i[LinesW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted panel for the clip stages.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_area_q   <= in_area;
      item_usable_q <= s_axis_tuser_i[2];
      item_mon_q    <= s_axis_tuser_i[3];
    end
  end

  pbrf_clip u_clip (
    .clk_i  (clk_i),
    .area_i (item_area_q),
    .geom_i (geom_q),
    .res_o  (clip_res)
  );

  // Exclusions are written on acceptance and kept rectangles at the end of their
  // item; reads start in a later item, so no access to one entry can overlap.
  pbrf_ram #(
    .Width ($bits(area_t)),
    .Depth (MaxExclude)
  ) u_excl_ram (
    .clk_i   (clk_i),
    .we_i    (excl_we),
    .waddr_i (excl_cnt_q[ExclAddrW-1:0]),
    .wdata_i (in_area),
    .re_i    (excl_re),
    .raddr_i (idx_q[ExclAddrW-1:0]),
    .rdata_o (excl_rdata)
  );

  pbrf_ram #(
    .Width ($bits(loc_rect_t)),
    .Depth (MaxLines)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (kept_cnt_q[KeptAddrW-1:0]),
    .wdata_i (loc_q),
    .re_i    (kept_re),
    .raddr_i (idx_q[KeptAddrW-1:0]),
    .rdata_o (kept_rdata)
  );

  assign ex = area_t'(excl_rdata);
  assign kr = loc_rect_t'(kept_rdata);

  // Overlap with the stored region shrunk by one pixel on every side.
  always_comb begin
    logic signed [CmpW-1:0] shl, sht, shr, shb, ll, lt, lr, lb;
    shl = CmpW'(ex.l) + CmpW'(1);
    sht = CmpW'(ex.t) + CmpW'(1);
    shr = CmpW'(ex.r) - CmpW'(1);
    shb = CmpW'(ex.b) - CmpW'(1);
    ll  = $signed({{(CmpW-LocW){1'b0}}, loc_q.l});
    lt  = $signed({{(CmpW-LocW){1'b0}}, loc_q.t});
    lr  = $signed({{(CmpW-LocW){1'b0}}, loc_q.r});
    lb  = $signed({{(CmpW-LocW){1'b0}}, loc_q.b});
    blocked = (shr > shl) && (shb > sht) &&
              (ll < shr) && (shl < lr) && (lt < shb) && (sht < lb);
  end

  assign dup   = (kr == loc_q);
  assign limit = (max_lines_q > LinesW'(MaxLines)) ? KeptCntW'(MaxLines)
                                                   : KeptCntW'(max_lines_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      res_status_q <= ST_ACK;
      res_slot_q   <= '0;
      excl_cnt_q   <= '0;
      kept_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      excl_cnt_q   <= excl_cnt_d;
      kept_cnt_q   <= kept_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    loc_q <= loc_d;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    excl_cnt_d   = excl_cnt_q;
    kept_cnt_d   = kept_cnt_q;
    loc_d        = loc_q;
    excl_we      = 1'b0;
    excl_re      = 1'b0;
    kept_we      = 1'b0;
    kept_re      = 1'b0;
    issue        = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          res_slot_d   = '0;
          res_status_d = ST_ACK;
          state_d      = FSM_RESP;
          case (in_req)
            REQ_CLEAR: begin
              excl_cnt_d = '0;
              kept_cnt_d = '0;
            end
            REQ_EXCL: begin
              if (excl_cnt_q >= ExclCntW'(MaxExclude)) begin
                res_status_d = ST_FULL;
              end else begin
                excl_we    = 1'b1;
                excl_cnt_d = excl_cnt_q + 1'b1;
              end
            end
            REQ_PANEL: state_d = FSM_CLIP;
            default: ;
          endcase
        end
      end

      FSM_CLIP: state_d = FSM_CHECK;

      FSM_CHECK: begin
        state_d = FSM_RESP;
        if (kept_cnt_q >= limit) begin
          res_status_d = ST_LIMIT;
        end else if (!item_usable_q || item_mon_q) begin
          res_status_d = ST_SKIP;
        end else if (clip_res.empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          loc_d   = clip_res.loc;
          idx_d   = '0;
          pend_d  = 1'b0;
          state_d = FSM_SCAN_EXCL;
        end
      end

      FSM_SCAN_EXCL: begin
        issue   = (idx_q < IdxW'(excl_cnt_q));
        excl_re = issue;
        pend_d  = issue;
        if (issue) idx_d = idx_q + 1'b1;
        if (pend_q && blocked) begin
          res_status_d = ST_BLOCKED;
          pend_d       = 1'b0;
          state_d      = FSM_RESP;
        end else if (!issue) begin
          idx_d   = '0;
          state_d = FSM_SCAN_KEPT;
        end
      end

      FSM_SCAN_KEPT: begin
        issue   = (idx_q < IdxW'(kept_cnt_q));
        kept_re = issue;
        pend_d  = issue;
        if (issue) idx_d = idx_q + 1'b1;
        if (pend_q && dup) begin
          res_status_d = ST_DUP;
          pend_d       = 1'b0;
          state_d      = FSM_RESP;
        end else if (!issue) begin
          kept_we      = 1'b1;
          res_status_d = ST_KEPT;
          res_slot_d   = kept_cnt_q[SlotW-1:0];
          kept_cnt_d   = kept_cnt_q + 1'b1;
          state_d      = FSM_RESP;
        end
      end

      FSM_RESP: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = FSM_IDLE;
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_user_q <= res_status_q;
      if (res_status_q == ST_KEPT) begin
        m_data_q <= {{(OutDataW - 4*LocW - SlotW){1'b0}}, res_slot_q,
                     loc_q.b, loc_q.r, loc_q.t, loc_q.l};
      end else begin
        m_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_excl_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    excl_cnt_q <= ExclCntW'(MaxExclude))
    else $error("exclusion count beyond capacity");

  a_kept_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= KeptCntW'(MaxLines))
    else $error("kept count beyond capacity");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req == REQ_CLEAR) |=> (excl_cnt_q == '0 && kept_cnt_q == '0))
    else $error("clear item did not reset the counts");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_user_q != ST_KEPT) |-> (m_data_q == '0))
    else $error("rejected result carries a rectangle");

  a_kept_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == ST_KEPT) |-> (loc_q.r > loc_q.l && loc_q.b > loc_q.t))
    else $error("kept rectangle is empty");

endmodule

[tb/sv/tb_panel_border_rect_filter.sv]
// Self-checking stream testbench for the panel border rectangle filter.
`timescale 1ns / 1ps
module tb_panel_border_rect_filter;
  import pbrf_pkg::*;

  localparam int IdlePct = 22;
  localparam int TargetItems = 1925;

  typedef struct packed {
    status_e         st;
    loc_rect_t       loc;
    logic [SlotW-1:0] slot;
  } border_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_axis_tvalid_o;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  // Shadow of the block: registers and per-frame memories
  geom_t            geo = '0;
  logic [LinesW-1:0] lines_reg = LinesW'(MaxLines);
  area_t            excl_store[MaxExclude];
  int               excl_used = 0;
  loc_rect_t        kept_store[MaxLines];
  int               kept_used = 0;

  border_res_t results_due[$];
  int          errors = 0;
  int          n_sent = 0;
  bit          calm = 1'b0;

  panel_border_rect_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int rnd(int lo, int hi);
    return (hi <= lo) ? lo : lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic area_t make_area(int l, int t, int r, int b);
    area_t a;
    a.l = CoordW'(clamp(l, -65536, 65535));
    a.t = CoordW'(clamp(t, -65536, 65535));
    a.r = CoordW'(clamp(r, -65536, 65535));
    a.b = CoordW'(clamp(b, -65536, 65535));
    return a;
  endfunction

  // Outcome of one item; updates the shadow memories like the block does.
  function automatic border_res_t predict_border(req_e req, area_t a, logic usable,
                                                 logic monitor);
    border_res_t res;
    loc_rect_t   loc;
    int al, at, ar, ab, l, t, r, b, ol, ot, lim;
    int sl, st, sr, sb;
    res = '0;
    res.st = ST_ACK;
    al = $signed(a.l);
    at = $signed(a.t);
    ar = $signed(a.r);
    ab = $signed(a.b);
    case (req)
      REQ_CLEAR: begin
        excl_used = 0;
        kept_used = 0;
      end
      REQ_EXCL: begin
        if (excl_used >= MaxExclude) begin
          res.st = ST_FULL;
        end else begin
          excl_store[excl_used] = a;
          excl_used++;
        end
      end
      REQ_PANEL: begin
        lim = (lines_reg > MaxLines) ? MaxLines : int'(lines_reg);
        if (kept_used >= lim) begin
          res.st = ST_LIMIT;
        end else if (!usable || monitor) begin
          res.st = ST_SKIP;
        end else begin
          ol = $signed(geo.left);
          ot = $signed(geo.top);
          l = clamp(al + $signed(geo.org_x), ol, 1 << 20);
          t = clamp(at + $signed(geo.org_y), ot, 1 << 20);
          r = clamp(ar + $signed(geo.org_x), -(1 << 20), $signed(geo.right));
          b = clamp(ab + $signed(geo.org_y), -(1 << 20), $signed(geo.bottom));
          if (ar <= al || ab <= at || r - l <= 0 || b - t <= 0) begin
            res.st = ST_EMPTY;
          end else begin
            l -= ol; r -= ol;
            t -= ot; b -= ot;
            loc.l = LocW'(l); loc.t = LocW'(t);
            loc.r = LocW'(r); loc.b = LocW'(b);
            res.st = ST_KEPT;
            // a region blocks only by its inside, one pixel in from each edge
            for (int i = 0; i < excl_used; i++) begin
              sl = $signed(excl_store[i].l) + 1;
              st = $signed(excl_store[i].t) + 1;
              sr = $signed(excl_store[i].r) - 1;
              sb = $signed(excl_store[i].b) - 1;
              if (sr > sl && sb > st && l < sr && sl < r && t < sb && st < b)
                res.st = ST_BLOCKED;
            end
            if (res.st == ST_KEPT)
              for (int i = 0; i < kept_used; i++)
                if (kept_store[i] == loc) res.st = ST_DUP;
            if (res.st == ST_KEPT) begin
              res.loc = loc;
              res.slot = SlotW'(kept_used);
              kept_store[kept_used] = loc;
              kept_used++;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_item(req_e req, area_t a, logic usable, logic monitor);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {{(InDataW - 4 * CoordW){1'b0}}, a};
    s_tuser <= {monitor, usable, req};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    results_due = {results_due, predict_border(req, a, usable, monitor)};
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_addr_e idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CFG_OVL_LEFT:   geo.left = val;
      CFG_OVL_TOP:    geo.top = val;
      CFG_OVL_RIGHT:  geo.right = val;
      CFG_OVL_BOTTOM: geo.bottom = val;
      CFG_ORIGIN_X:   geo.org_x = val;
      CFG_ORIGIN_Y:   geo.org_y = val;
      CFG_MAX_LINES:  lines_reg = val[LinesW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int left, int top, int right, int bottom, int ox, int oy,
                              int lines);
    settle();
    write_reg(CFG_OVL_LEFT, CfgW'(left));
    write_reg(CFG_OVL_TOP, CfgW'(top));
    write_reg(CFG_OVL_RIGHT, CfgW'(right));
    write_reg(CFG_OVL_BOTTOM, CfgW'(bottom));
    write_reg(CFG_ORIGIN_X, CfgW'(ox));
    write_reg(CFG_ORIGIN_Y, CfgW'(oy));
    write_reg(CFG_MAX_LINES, CfgW'(lines));
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    border_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: status %0d", m_axis_tuser_o);
      end else begin
        want = results_due.pop_front();
        check_field("status", 16'(want.st), 16'(m_axis_tuser_o[2:0]));
        check_field("local_left", want.loc.l, m_axis_tdata_o[15:0]);
        check_field("local_top", want.loc.t, m_axis_tdata_o[31:16]);
        check_field("local_right", want.loc.r, m_axis_tdata_o[47:32]);
        check_field("local_bottom", want.loc.b, m_axis_tdata_o[63:48]);
        check_field("slot", 16'(want.slot), 16'(m_axis_tdata_o[67:64]));
      end
    end
    m_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Registers at reset leave an empty overlay; the unused code only acks.
  task automatic test_reset_config();
    send_item(REQ_PANEL, make_area(0, 0, 10, 10), 1'b1, 1'b0);
    send_item(REQ_RSVD, make_area(-65536, 65535, -1, 0), 1'b1, 1'b1);
  endtask

  task automatic test_clip_extremes();
    apply_config(-32768, -32768, 32767, 32767, 32767, -32768, 31);
    send_item(REQ_CLEAR, make_area(0, 0, 0, 0), 1'b0, 1'b0);
    send_item(REQ_PANEL, make_area(-65536, -65536, 65535, 65535), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(-65536, -65536, 65535, 65535), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(0, 0, 100, 100), 1'b0, 1'b0);
    send_item(REQ_PANEL, make_area(0, 0, 100, 100), 1'b1, 1'b1);
    send_item(REQ_PANEL, make_area(50, 0, 50, 100), 1'b1, 1'b0);
  endtask

  task automatic test_exclusion_rules();
    apply_config(100, 50, 900, 650, 10, 20, 2);
    send_item(REQ_CLEAR, make_area(0, 0, 0, 0), 1'b0, 1'b0);
    send_item(REQ_EXCL, make_area(100, 100, 200, 200), 1'b0, 1'b0);
    // shrinks to nothing, so it never blocks
    send_item(REQ_EXCL, make_area(300, 300, 301, 400), 1'b0, 1'b0);
    send_item(REQ_PANEL, make_area(90, 30, 191, 131), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(90, 30, 192, 132), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(380, 320, 400, 440), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(0, 0, 20, 20), 1'b1, 1'b0);
    send_item(REQ_PANEL, make_area(0, 0, 20, 20), 1'b0, 1'b1);
    for (int i = 0; i < MaxExclude - 1; i++)
      send_item(REQ_EXCL, make_area(10 * i, 0, 10 * i + 5, 5), 1'b0, 1'b0);
  endtask

  task automatic test_zero_limit();
    apply_config(0, 0, 640, 480, 0, 0, 0);
    send_item(REQ_PANEL, make_area(10, 10, 20, 20), 1'b1, 1'b0);
  endtask

  // One register setting, then a few frames of exclusions and panels.
  task automatic run_frames(int n_frames);
    area_t recent[$];
    area_t a;
    int left, top, w, h, ox, oy, lines, n_excl, n_panel, pl, pt, pw, ph;
    case ($urandom_range(5))
      0: begin
        left = -32768; top = -32768; w = 65535; h = 65535;
        ox = ($urandom_range(1)) ? rnd(-32768, 32767) : (($urandom_range(1)) ? 32767 : -32768);
        oy = ($urandom_range(1)) ? rnd(-32768, 32767) : (($urandom_range(1)) ? 32767 : -32768);
      end
      4: begin
        left = rnd(-32768, 32760); top = rnd(-32768, 32760);
        w = rnd(1, 4); h = rnd(1, 4);
        ox = rnd(-32768, 32767); oy = rnd(-32768, 32767);
      end
      5: begin
        left = rnd(-100, 100); top = rnd(-100, 100);
        w = -rnd(0, 20); h = rnd(-5, 300);
        ox = rnd(-200, 200); oy = rnd(-200, 200);
      end
      default: begin
        left = rnd(-3000, 3000); top = rnd(-3000, 3000);
        w = rnd(1, 2000); h = rnd(1, 2000);
        ox = rnd(-4000, 4000); oy = rnd(-4000, 4000);
      end
    endcase
    case ($urandom_range(7))
      0: lines = 0;
      1: lines = 1;
      2: lines = MaxLines;
      3: lines = rnd(MaxLines + 1, 31);
      default: lines = rnd(2, MaxLines);
    endcase
    apply_config(left, top, left + w, top + h, ox, oy, lines);
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    for (int f = 0; f < n_frames; f++) begin
      // now and then carry the old frame across the register change
      if (f > 0 || $urandom_range(9) < 7)
        send_item(REQ_CLEAR, make_area(rnd(-65536, 65535), 0, 0, 0), 1'b0, 1'b0);
      recent.delete();
      n_excl = ($urandom_range(7) == 0) ? rnd(MaxExclude, MaxExclude + 3) : rnd(0, 4);
      for (int i = 0; i < n_excl; i++) begin
        pl = rnd(-2, w); pt = rnd(-2, h);
        send_item(REQ_EXCL, make_area(pl, pt, pl + rnd(-1, w / 6 + 3), pt + rnd(-1, h / 6 + 3)),
                  1'b0, 1'b0);
      end
      n_panel = rnd(1, 24);
      for (int i = 0; i < n_panel; i++) begin
        if ($urandom_range(9) == 0) begin
          a.l = CoordW'($urandom); a.t = CoordW'($urandom);
          a.r = CoordW'($urandom); a.b = CoordW'($urandom);
          send_item(req_e'($urandom_range(3)), a, 1'($urandom), 1'($urandom));
        end else begin
          if (recent.size() != 0 && $urandom_range(4) == 0) begin
            a = recent[$urandom_range(recent.size() - 1)];
          end else begin
            pl = rnd(-w / 8 - 2, w - 1); pt = rnd(-h / 8 - 2, h - 1);
            pw = ($urandom_range(19) == 0) ? -rnd(0, 3) : rnd(1, w / 3 + 1);
            ph = ($urandom_range(19) == 0) ? -rnd(0, 3) : rnd(1, h / 3 + 1);
            a = make_area(pl + left - ox, pt + top - oy, pl + pw + left - ox,
                          pt + ph + top - oy);
            recent = {recent, a};
          end
          send_item(REQ_PANEL, a, $urandom_range(24) != 0, $urandom_range(24) == 0);
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    run_frames(3);
    run_frames(2);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_random_frames();
    while (n_sent < TargetItems) run_frames(rnd(1, 4));
  endtask

  initial begin : run_tests
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_clip_extremes();
    test_exclusion_rules();
    test_zero_limit();
    test_back_to_back();
    test_random_frames();
    settle();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/pbrf_pkg.sv
design/pbrf_ram.sv
design/pbrf_clip.sv
design/panel_border_rect_filter.sv
tb/sv/tb_panel_border_rect_filter.sv
